>>> src/assert_macros.svh
// Assertion macros for the order book RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLOB_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define PLOB_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define PLOB_ASSERT(label, expr)
`define PLOB_ASSERT_NEXT(label, cond, expr)
`endif
`endif

>>> src/plob_pkg.sv
// Shared types and constants of the price level order book.
`timescale 1ns / 1ps
`default_nettype none
package plob_pkg;
    localparam int LEVELS = 64;

    localparam logic [47:0] VOL_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_REDUCE = 2'd2;
    // no-op command, leaves the book alone
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // cell operations
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_NEW  = 3'd2;
    localparam logic [2:0] OP_DEL  = 3'd3;
    localparam logic [2:0] OP_CNT  = 3'd4;
    localparam logic [2:0] OP_SUB  = 3'd5;

    typedef struct packed {
        logic        used;
        logic [31:0] price;
        logic [47:0] vol;
        logic [15:0] cnt;
    } lvl_t;

    typedef struct packed {
        logic        cmp;
        logic [2:0]  op;
        logic [31:0] price;
        logic [31:0] amt;
    } ctl_t;

    typedef struct packed {
        logic match;
        logic after;
        logic cnt_max;
        logic cnt_one;
    } flg_t;
endpackage
`default_nettype wire

>>> src/plob_if.sv
// Valid/ready channel interfaces for order commands and book results.
`timescale 1ns / 1ps
`default_nettype none
interface plob_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] new_qty;
    modport source (output valid, cmd, side, price, qty, new_qty, input ready);
    modport sink (input valid, cmd, side, price, qty, new_qty, output ready);
endinterface

interface plob_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] order_qty_after;
    logic        bid_valid;
    logic [31:0] best_bid_price;
    logic [47:0] best_bid_volume;
    logic        ask_valid;
    logic [31:0] best_ask_price;
    logic [47:0] best_ask_volume;
    modport source (output valid, status, order_qty_after, bid_valid, best_bid_price,
        best_bid_volume, ask_valid, best_ask_price, best_ask_volume, input ready);
    modport sink (input valid, status, order_qty_after, bid_valid, best_bid_price,
        best_bid_volume, ask_valid, best_ask_price, best_ask_volume, output ready);
endinterface
`default_nettype wire

>>> src/price_level_order_book_top.sv
// Top level of the price level order book.
//   channel | dir | beat contents
//   in_ch   | in  | cmd, side, price, qty, new_qty
//   out_ch  | out | status, order_qty_after, best bid and best ask
// A command is accepted, compared in every cell, applied as an update
// (shift or modify in place), then loaded into the result register.
// The result register holds a finished beat while the next command is latched.
// Reset empties both sides at once; no clearing pass.
// A stalled output holds the block in its last phase until the beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module price_level_order_book_top (
    input  wire        clk,
    input  wire        rst_n,
    plob_in_if.sink    in_ch,
    plob_out_if.source out_ch
);
    import plob_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [1:0]  cmd_reg;
    logic        side_reg;
    logic [31:0] price_reg;
    logic [31:0] qty_reg;
    logic [31:0] nq_reg;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [31:0] after_reg;
    logic [31:0] after_next;
    logic        oval_reg;
    logic [2:0]  op;
    logic [31:0] amt;
    ctl_t        bid_ctl;
    ctl_t        ask_ctl;
    lvl_t        bid_head;
    lvl_t        ask_head;
    logic        bid_found, bid_max, bid_last, bid_full;
    logic        ask_found, ask_max, ask_last, ask_full;
    logic        found, at_max, last, full;
    logic        load;

    assign found  = side_reg ? ask_found : bid_found;
    assign at_max = side_reg ? ask_max   : bid_max;
    assign last   = side_reg ? ask_last  : bid_last;
    assign full   = side_reg ? ask_full  : bid_full;

    always_comb
    begin
        op          = OP_NONE;
        amt         = qty_reg;
        status_next = ST_DONE;
        after_next  = qty_reg;
        case (cmd_reg)
            CMD_INSERT:
            begin
                if (found)
                begin
                    if (at_max) status_next = ST_FULL;
                    else        op = OP_ADD;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op = OP_NEW;
                end
            end
            CMD_CANCEL:
            begin
                if (!found)
                begin
                    status_next = ST_MISSING;
                end
                else
                begin
                    op         = last ? OP_DEL : OP_CNT;
                    after_next = 32'd0;
                end
            end
            CMD_REDUCE:
            begin
                amt = qty_reg - nq_reg;
                if (nq_reg >= qty_reg)
                begin
                    status_next = ST_IGNORED;
                end
                else
                begin
                    after_next = nq_reg;
                    if (found) op = OP_SUB;
                    else       status_next = ST_MISSING;
                end
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        bid_ctl.cmp   = state_reg == S_CMP;
        bid_ctl.price = price_reg;
        bid_ctl.amt   = amt;
        bid_ctl.op    = (state_reg == S_UPD && !side_reg) ? op : OP_NONE;
        ask_ctl       = bid_ctl;
        ask_ctl.op    = (state_reg == S_UPD && side_reg) ? op : OP_NONE;
    end

    plob_row u_bid (
        .clk    (clk),
        .rst_n  (rst_n),
        .is_ask (1'b0),
        .ctl    (bid_ctl),
        .head   (bid_head),
        .found  (bid_found),
        .at_max (bid_max),
        .last   (bid_last),
        .full   (bid_full)
    );

    plob_row u_ask (
        .clk    (clk),
        .rst_n  (rst_n),
        .is_ask (1'b1),
        .ctl    (ask_ctl),
        .head   (ask_head),
        .found  (ask_found),
        .at_max (ask_max),
        .last   (ask_last),
        .full   (ask_full)
    );

    assign load = (state_reg == S_OUT) && (!oval_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_ch.valid) state_next = S_CMP;
            S_CMP:  state_next = S_UPD;
            S_UPD:  state_next = S_OUT;
            S_OUT:  if (load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                oval_reg <= 1'b1;
            else if (out_ch.ready)
                oval_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            cmd_reg   <= in_ch.cmd;
            side_reg  <= in_ch.side;
            price_reg <= in_ch.price;
            qty_reg   <= in_ch.qty;
            nq_reg    <= in_ch.new_qty;
        end
        if (state_reg == S_UPD)
        begin
            status_reg <= status_next;
            after_reg  <= after_next;
        end
        if (load)
        begin
            out_ch.status          <= status_reg;
            out_ch.order_qty_after <= after_reg;
            out_ch.bid_valid       <= bid_head.used;
            out_ch.best_bid_price  <= bid_head.used ? bid_head.price : 32'd0;
            out_ch.best_bid_volume <= bid_head.used ? bid_head.vol : 48'd0;
            out_ch.ask_valid       <= ask_head.used;
            out_ch.best_ask_price  <= ask_head.used ? ask_head.price : 32'd0;
            out_ch.best_ask_volume <= ask_head.used ? ask_head.vol : 48'd0;
        end
    end

    assign in_ch.ready  = state_reg == S_IDLE;
    assign out_ch.valid = oval_reg;
endmodule
`default_nettype wire

>>> src/plob_cell.sv
// One price level cell of a sorted level row.
`timescale 1ns / 1ps
`default_nettype none
module plob_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 is_ask,
    input  plob_pkg::ctl_t      ctl,
    input  plob_pkg::lvl_t      left_lvl,
    input  wire                 left_pos,
    input  plob_pkg::lvl_t      right_lvl,
    output plob_pkg::lvl_t      lvl,
    output plob_pkg::flg_t      flg,
    output logic                pos
);
    import plob_pkg::*;

    lvl_t        lvl_reg;
    lvl_t        lvl_next;
    flg_t        flg_reg;
    flg_t        flg_next;
    logic        del;
    logic [48:0] vol_sum;
    logic [47:0] vol_add;
    logic [47:0] vol_sub;

    assign lvl = lvl_reg;
    assign flg = flg_reg;
    // insertion point and everything behind it
    assign pos = flg_reg.after || !lvl_reg.used;
    assign del = flg_reg.match || flg_reg.after;

    assign vol_sum = {1'b0, lvl_reg.vol} + {17'd0, ctl.amt};
    assign vol_add = vol_sum[48] ? VOL_MAX : vol_sum[47:0];
    assign vol_sub = (lvl_reg.vol > {16'd0, ctl.amt}) ? lvl_reg.vol - {16'd0, ctl.amt}
                                                      : 48'd0;

    always_comb
    begin
        flg_next.match   = lvl_reg.used && (lvl_reg.price == ctl.price);
        flg_next.after   = lvl_reg.used && (is_ask ? (lvl_reg.price > ctl.price)
                                                   : (lvl_reg.price < ctl.price));
        flg_next.cnt_max = lvl_reg.cnt == CNT_MAX;
        flg_next.cnt_one = lvl_reg.cnt <= 16'd1;
    end

    always_comb
    begin
        lvl_next = lvl_reg;
        case (ctl.op)
            OP_ADD:
            begin
                if (flg_reg.match)
                begin
                    lvl_next.cnt = lvl_reg.cnt + 16'd1;
                    lvl_next.vol = vol_add;
                end
            end
            OP_NEW:
            begin
                if (left_pos)
                begin
                    lvl_next = left_lvl;
                end
                else if (pos)
                begin
                    lvl_next.used  = 1'b1;
                    lvl_next.price = ctl.price;
                    lvl_next.vol   = {16'd0, ctl.amt};
                    lvl_next.cnt   = 16'd1;
                end
            end
            OP_DEL:
            begin
                if (del)
                begin
                    lvl_next = right_lvl;
                end
            end
            OP_CNT:
            begin
                if (flg_reg.match)
                begin
                    lvl_next.cnt = lvl_reg.cnt - 16'd1;
                    lvl_next.vol = vol_sub;
                end
            end
            OP_SUB:
            begin
                if (flg_reg.match)
                begin
                    lvl_next.vol = vol_sub;
                end
            end
            default:
            begin
                lvl_next = lvl_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg <= '0;
            flg_reg <= '0;
        end
        else
        begin
            lvl_reg <= lvl_next;
            if (ctl.cmp)
            begin
                flg_reg <= flg_next;
            end
        end
    end
endmodule
`default_nettype wire

>>> src/plob_row.sv
// Sorted row of level cells for one book side, best level at cell 0.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module plob_row (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 is_ask,
    input  plob_pkg::ctl_t      ctl,
    output plob_pkg::lvl_t      head,
    output logic                found,
    output logic                at_max,
    output logic                last,
    output logic                full
);
    import plob_pkg::*;

    lvl_t              lvl [LEVELS];
    flg_t              flg [LEVELS];
    logic [LEVELS-1:0] pos;
    logic [LEVELS-1:0] match_vec;
    logic [LEVELS-1:0] max_vec;
    logic [LEVELS-1:0] one_vec;
    logic              order_ok;

    genvar i;
    generate
        for (i = 0; i < LEVELS; i++)
        begin : g_cell
            lvl_t left_lvl;
            lvl_t right_lvl;
            logic left_pos;
            if (i == 0)
            begin : g_first
                assign left_lvl = '0;
                assign left_pos = 1'b0;
            end
            else
            begin : g_mid
                assign left_lvl = lvl[i-1];
                assign left_pos = pos[i-1];
            end
            if (i == LEVELS - 1)
            begin : g_last
                assign right_lvl = '0;
            end
            else
            begin : g_inner
                assign right_lvl = lvl[i+1];
            end
            plob_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .is_ask    (is_ask),
                .ctl       (ctl),
                .left_lvl  (left_lvl),
                .left_pos  (left_pos),
                .right_lvl (right_lvl),
                .lvl       (lvl[i]),
                .flg       (flg[i]),
                .pos       (pos[i])
            );
            assign match_vec[i] = flg[i].match;
            assign max_vec[i]   = flg[i].match && flg[i].cnt_max;
            assign one_vec[i]   = flg[i].match && flg[i].cnt_one;
        end
    endgenerate

    assign head   = lvl[0];
    assign found  = |match_vec;
    assign at_max = |max_vec;
    assign last   = |one_vec;
    assign full   = lvl[LEVELS-1].used;

    assign order_ok = is_ask ? (lvl[0].price < lvl[1].price) : (lvl[0].price > lvl[1].price);

    // the first two used levels stay packed at the front, in strict price order
    `PLOB_ASSERT(a_packed, !lvl[1].used || lvl[0].used)
    `PLOB_ASSERT(a_unique_match, $onehot0(match_vec))
    `PLOB_ASSERT(a_order, !lvl[1].used || order_ok)
endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench of the price level order book: predicted book state vs. result beats.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import plob_pkg::*;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
        logic [31:0] new_qty;
    } order_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] qty_after;
        logic        bid_valid;
        logic [31:0] bid_price;
        logic [47:0] bid_vol;
        logic        ask_valid;
        logic [31:0] ask_price;
        logic [47:0] ask_vol;
    } quote_t;

    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    plob_in_if  in_ch ();
    plob_out_if out_ch ();

    price_level_order_book_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted book, index 0 bids, 1 asks
    logic [31:0] book_price [2][LEVELS];
    logic [47:0] book_vol [2][LEVELS];
    logic [15:0] book_cnt [2][LEVELS];
    logic        book_used [2][LEVELS];

    order_t pending_orders [$];
    quote_t expected_quotes [$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_off = 0;
    int     errors = 0;
    int     accepted = 0;
    int     received = 0;
    int     quiet_cycles = 0;
    bit     timed_out = 1'b0;
    bit     in_fire = 1'b0;
    int     status_seen [4];

    function automatic void queue_order(order_t o);
        pending_orders.insert(pending_orders.size(), o);
    endfunction

    function automatic quote_t apply_order(order_t o);
        quote_t q;
        int s;
        int f;
        int sd;
        logic [48:0] sum;
        logic [47:0] dec;
        logic [47:0] qty48;
        sd = o.side;
        s = -1;
        f = -1;
        qty48 = {16'd0, o.qty};
        for (int i = 0; i < LEVELS; i++)
        begin
            if (s < 0 && book_used[sd][i] && book_price[sd][i] == o.price)
                s = i;
            if (f < 0 && !book_used[sd][i])
                f = i;
        end
        q = '0;
        q.status = ST_DONE;
        q.qty_after = o.qty;
        if (o.cmd == CMD_INSERT)
        begin
            if (s >= 0)
            begin
                if (book_cnt[sd][s] == CNT_MAX)
                    q.status = ST_FULL;
                else
                begin
                    book_cnt[sd][s]++;
                    sum = {1'b0, book_vol[sd][s]} + {17'd0, o.qty};
                    book_vol[sd][s] = sum[48] ? VOL_MAX : sum[47:0];
                end
            end
            else if (f < 0)
                q.status = ST_FULL;
            else
            begin
                book_used[sd][f] = 1'b1;
                book_price[sd][f] = o.price;
                book_vol[sd][f] = qty48;
                book_cnt[sd][f] = 16'd1;
            end
        end
        else if (o.cmd == CMD_CANCEL)
        begin
            if (s < 0)
                q.status = ST_MISSING;
            else
            begin
                book_vol[sd][s] = book_vol[sd][s] > qty48 ? book_vol[sd][s] - qty48 : '0;
                if (book_cnt[sd][s] != 0)
                    book_cnt[sd][s]--;
                if (book_cnt[sd][s] == 0)
                    book_used[sd][s] = 1'b0;
                q.qty_after = '0;
            end
        end
        else if (o.cmd == CMD_REDUCE)
        begin
            if (o.new_qty >= o.qty)
                q.status = ST_IGNORED;
            else
            begin
                q.qty_after = o.new_qty;
                if (s < 0)
                    q.status = ST_MISSING;
                else
                begin
                    dec = {16'd0, o.qty - o.new_qty};
                    book_vol[sd][s] = book_vol[sd][s] > dec ? book_vol[sd][s] - dec : '0;
                end
            end
        end
        for (int i = 0; i < LEVELS; i++)
        begin
            if (book_used[0][i] && (!q.bid_valid || book_price[0][i] > q.bid_price))
            begin
                q.bid_valid = 1'b1;
                q.bid_price = book_price[0][i];
                q.bid_vol = book_vol[0][i];
            end
            if (book_used[1][i] && (!q.ask_valid || book_price[1][i] < q.ask_price))
            begin
                q.ask_valid = 1'b1;
                q.ask_price = book_price[1][i];
                q.ask_vol = book_vol[1][i];
            end
        end
        return q;
    endfunction

    // driver
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.cmd = '0;
        in_ch.side = 1'b0;
        in_ch.price = '0;
        in_ch.qty = '0;
        in_ch.new_qty = '0;
        out_ch.ready = 1'b0;
    end

    // a new beat goes out once the last one was taken at the previous rising edge
    always @(negedge clk)
    begin
        if (rst_n && (!in_ch.valid || in_fire))
        begin
            if (pending_orders.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                order_t o;
                o = pending_orders.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.cmd <= o.cmd;
                in_ch.side <= o.side;
                in_ch.price <= o.price;
                in_ch.qty <= o.qty;
                in_ch.new_qty <= o.new_qty;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= rst_n && $urandom_range(99) >= recv_stall_pct;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (in_ch.valid && in_ch.ready)
            begin
                expected_quotes.insert(expected_quotes.size(),
                    apply_order({in_ch.cmd, in_ch.side, in_ch.price, in_ch.qty,
                    in_ch.new_qty}));
                accepted <= accepted + 1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                received <= received + 1;
                if (expected_quotes.size() == 0)
                begin
                    $error("result beat with no order waiting");
                    errors++;
                end
                else
                begin
                    quote_t e;
                    e = expected_quotes.pop_front();
                    status_seen[out_ch.status]++;
                    if (out_ch.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, out_ch.status);
                        errors++;
                    end
                    if (out_ch.order_qty_after !== e.qty_after)
                    begin
                        $error("order_qty_after exp %0d got %0d", e.qty_after,
                            out_ch.order_qty_after);
                        errors++;
                    end
                    if (out_ch.bid_valid !== e.bid_valid)
                    begin
                        $error("bid_valid exp %0d got %0d", e.bid_valid, out_ch.bid_valid);
                        errors++;
                    end
                    if (out_ch.best_bid_price !== e.bid_price)
                    begin
                        $error("best_bid_price exp %0d got %0d", e.bid_price,
                            out_ch.best_bid_price);
                        errors++;
                    end
                    if (out_ch.best_bid_volume !== e.bid_vol)
                    begin
                        $error("best_bid_volume exp %0d got %0d", e.bid_vol,
                            out_ch.best_bid_volume);
                        errors++;
                    end
                    if (out_ch.ask_valid !== e.ask_valid)
                    begin
                        $error("ask_valid exp %0d got %0d", e.ask_valid, out_ch.ask_valid);
                        errors++;
                    end
                    if (out_ch.best_ask_price !== e.ask_price)
                    begin
                        $error("best_ask_price exp %0d got %0d", e.ask_price,
                            out_ch.best_ask_price);
                        errors++;
                    end
                    if (out_ch.best_ask_volume !== e.ask_vol)
                    begin
                        $error("best_ask_volume exp %0d got %0d", e.ask_vol,
                            out_ch.best_ask_volume);
                        errors++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG)
                timed_out = 1'b1;
        end
    end

    function automatic order_t make_order(logic [1:0] c, logic sd, logic [31:0] p,
                                          logic [31:0] q, logic [31:0] nq);
        order_t o;
        o.cmd = c;
        o.side = sd;
        o.price = p;
        o.qty = q;
        o.new_qty = nq;
        return o;
    endfunction

    // random order from a small price band so levels are hit repeatedly
    function automatic order_t random_order(int band);
        order_t o;
        int r;
        r = $urandom_range(99);
        o.side = 1'($urandom_range(1));
        o.price = (r < 90) ? 32'(1000 + $urandom_range(band)) : $urandom;
        o.qty = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000);
        o.new_qty = ($urandom_range(1) == 0) ? $urandom_range(o.qty) : $urandom;
        r = $urandom_range(99);
        o.cmd = (r < 50) ? CMD_INSERT : (r < 78) ? CMD_CANCEL : (r < 98) ? CMD_REDUCE
                                                                          : CMD_SPARE;
        return o;
    endfunction

    task automatic drain();
        wait (pending_orders.size() == 0 && !in_ch.valid);
        while (expected_quotes.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic run_phase(int n, int idle, int stall, int band);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            queue_order(random_order(band));
        drain();
    endtask

    initial
    begin
        for (int sd = 0; sd < 2; sd++)
            for (int i = 0; i < LEVELS; i++)
            begin
                book_used[sd][i] = 1'b0;
                book_price[sd][i] = '0;
                book_vol[sd][i] = '0;
                book_cnt[sd][i] = '0;
            end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty book misses, extremes, saturation, ignored reduce, spare command
        queue_order(make_order(CMD_CANCEL, 1'b0, 32'd5, 32'd1, 32'd0));
        queue_order(make_order(CMD_REDUCE, 1'b1, 32'd5, 32'd9, 32'd3));
        queue_order(make_order(CMD_INSERT, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF));
        queue_order(make_order(CMD_INSERT, 1'b0, 32'd0, 32'd0, 32'd0));
        queue_order(make_order(CMD_INSERT, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0));
        queue_order(make_order(CMD_INSERT, 1'b1, 32'hFFFF_FFFF, 32'd7, 32'd0));
        queue_order(make_order(CMD_REDUCE, 1'b0, 32'hFFFF_FFFF, 32'd5, 32'd5));
        queue_order(make_order(CMD_REDUCE, 1'b0, 32'hFFFF_FFFF, 32'd5, 32'd9));
        queue_order(make_order(CMD_REDUCE, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0));
        queue_order(make_order(CMD_CANCEL, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0));
        queue_order(make_order(CMD_SPARE, 1'b1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd1));
        queue_order(make_order(CMD_INSERT, 1'b0, 32'd0, 32'd4, 32'd0));
        queue_order(make_order(CMD_CANCEL, 1'b0, 32'd0, 32'd100, 32'd0));
        queue_order(make_order(CMD_CANCEL, 1'b0, 32'd0, 32'd0, 32'd0));
        queue_order(make_order(CMD_CANCEL, 1'b0, 32'd0, 32'd0, 32'd0));
        drain();

        // fill the bid table past capacity while the receiver holds off
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 300;
        for (int i = 0; i < LEVELS + 3; i++)
            queue_order(make_order(CMD_INSERT, 1'b0, 32'(2000 + i), $urandom, $urandom));
        drain();
        // pile large quantities onto one level's volume
        for (int i = 0; i < 70; i++)
            queue_order(make_order(CMD_INSERT, 1'b0, 32'd2000, 32'hFFFF_FFFF, 32'd0));
        drain();
        for (int i = 0; i < LEVELS + 3; i++)
            queue_order(make_order(CMD_CANCEL, 1'b0, 32'(2000 + i), 32'd1, 32'd0));
        drain();

        run_phase(400, 0, 0, 40);
        run_phase(300, 69, 0, 90);
        run_phase(300, 0, 69, 20);
        run_phase(250, 16, 16, 120);

        $display("Orders accepted: %0d, results checked: %0d", accepted, received);
        $display("Status mix done/missing/full/ignored: %0d/%0d/%0d/%0d",
            status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0 && !timed_out && expected_quotes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        wait (timed_out);
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
